>>> src/cvcc_pkg.sv
// Shared types, widths and constants of the CV to MIDI CC scanner.
`timescale 1ns / 1ps
`default_nettype none
package cvcc_pkg;

   localparam int NUM_CHANNELS_DEF = 64;
   localparam int NUM_CC_DEF       = 128;

   localparam int CH_FIELD_W = 6;
   localparam int CODE_W     = 16;
   localparam int MAPCC_W    = 8;
   localparam int CC_W       = 7;
   localparam int VAL_W      = 7;
   localparam int STAMP_W    = 48;
   localparam int ACC_W      = 17;
   localparam int CFG_W      = 16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 64;

   localparam logic [CFG_W-1:0] PHASE_STEP_RST  = 16'd1;
   localparam logic [CFG_W-1:0] EMIT_PERIOD_RST = 16'd240;

   localparam logic [MAPCC_W-1:0] CC_NONE   = 8'hFF;
   localparam logic [MAPCC_W-1:0] SENT_NONE = 8'hFF;

   localparam int QUANT_GAIN = 254;
   localparam int QUANT_BIAS = 32767;
   localparam int QUANT_DIV  = 65534;

   localparam logic REG_PHASE_STEP  = 1'b0;
   localparam logic REG_EMIT_PERIOD = 1'b1;

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_TICK   = 2'd1,
      OP_MAP    = 2'd2
   } op_type;

   typedef struct packed {
      logic [CFG_W-1:0] phase_step;
      logic [CFG_W-1:0] emit_period;
   } cfg_type;

   typedef struct packed {
      logic               fire;
      logic [STAMP_W-1:0] stamp;
   } tick_type;

endpackage
`default_nettype wire

>>> src/cvcc_csr.sv
// APB register block holding phase_step and emit_period.
`timescale 1ns / 1ps
`default_nettype none
module cvcc_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [cvcc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  wire logic [cvcc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic      [cvcc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                                   pready,
   output cvcc_pkg::cfg_type                      cfg
);

   logic [cvcc_pkg::CFG_W-1:0] phase_step_ff;
   logic [cvcc_pkg::CFG_W-1:0] emit_period_ff;
   logic                       wr_en;
   logic                       sel;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign sel    = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff  <= cvcc_pkg::PHASE_STEP_RST;
         emit_period_ff <= cvcc_pkg::EMIT_PERIOD_RST;
      end else if (wr_en) begin
         case (sel)
            cvcc_pkg::REG_PHASE_STEP:  phase_step_ff  <= pwdata[cvcc_pkg::CFG_W-1:0];
            cvcc_pkg::REG_EMIT_PERIOD: emit_period_ff <= pwdata[cvcc_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[1:0] == 2'b00) begin
         case (sel)
            cvcc_pkg::REG_PHASE_STEP:
               prdata = cvcc_pkg::CSR_DATA_W'(phase_step_ff);
            cvcc_pkg::REG_EMIT_PERIOD:
               prdata = cvcc_pkg::CSR_DATA_W'(emit_period_ff);
            default: prdata = '0;
         endcase
      end
   end

   assign cfg.phase_step  = phase_step_ff;
   assign cfg.emit_period = emit_period_ff;

endmodule
`default_nettype wire

>>> src/cvcc_rate.sv
// Rate accumulator and tick counter that decide when a scan fires.
`timescale 1ns / 1ps
`default_nettype none
module cvcc_rate (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              tick_accept,
   input  wire cvcc_pkg::cfg_type cfg,
   output cvcc_pkg::tick_type     tick
);

   localparam int SUM_W = cvcc_pkg::ACC_W + 1;

   logic [cvcc_pkg::ACC_W-1:0]   acc_ff;
   logic [cvcc_pkg::ACC_W-1:0]   acc_in;
   logic [cvcc_pkg::STAMP_W-1:0] tick_ff;
   logic [cvcc_pkg::STAMP_W-1:0] tick_in;
   logic [SUM_W-1:0]             sum;
   logic [SUM_W-1:0]             rem;
   logic                         reach;

   always_comb begin
      sum   = SUM_W'(acc_ff) + SUM_W'(cfg.phase_step);
      reach = sum >= SUM_W'(cfg.emit_period);
      rem   = reach ? sum - SUM_W'(cfg.emit_period) : sum;
      acc_in  = rem[SUM_W-1] ? '1 : rem[cvcc_pkg::ACC_W-1:0];
      tick_in = tick_ff + cvcc_pkg::STAMP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         tick_ff <= '0;
      end else if (tick_accept) begin
         acc_ff  <= acc_in;
         tick_ff <= tick_in;
      end
   end

   assign tick.fire  = reach;
   assign tick.stamp = tick_ff;

endmodule
`default_nettype wire

>>> src/cvcc_quant.sv
// Quantizer from a signed voltage code to a 0..127 controller level.
`timescale 1ns / 1ps
`default_nettype none
module cvcc_quant (
   input  wire logic signed [cvcc_pkg::CODE_W-1:0] code,
   output logic             [cvcc_pkg::VAL_W-1:0]  level
);

   localparam int N_W = 23;
   localparam int Q_SHIFT = 16;

   logic [N_W-1:0]               num;
   logic [N_W-1:0]               prod;
   logic [N_W-1:0]               rem;
   logic [cvcc_pkg::VAL_W-1:0]   q_est;
   logic [cvcc_pkg::VAL_W:0]     q;

   always_comb begin
      num   = N_W'(code[cvcc_pkg::CODE_W-2:0]) * N_W'(cvcc_pkg::QUANT_GAIN)
              + N_W'(cvcc_pkg::QUANT_BIAS);
      q_est = num[N_W-1:Q_SHIFT];
      prod  = {q_est, {Q_SHIFT{1'b0}}} - N_W'({q_est, 1'b0});
      rem   = num - prod;
      q     = (cvcc_pkg::VAL_W+1)'(q_est)
              + (cvcc_pkg::VAL_W+1)'(rem >= N_W'(cvcc_pkg::QUANT_DIV));
      if (code[cvcc_pkg::CODE_W-1]) begin
         level = '0;
      end else if (q[cvcc_pkg::VAL_W]) begin
         level = '1;
      end else begin
         level = q[cvcc_pkg::VAL_W-1:0];
      end
   end

endmodule
`default_nettype wire

>>> src/cvcc_engine.sv
// Memory sequencer: level, map and last-sent memories, bind sweep and scan.
`timescale 1ns / 1ps
`default_nettype none
module cvcc_engine #(
   parameter int NUM_CHANNELS = cvcc_pkg::NUM_CHANNELS_DEF,
   parameter int NUM_CC       = cvcc_pkg::NUM_CC_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   input  wire cvcc_pkg::op_type                    in_op,
   input  wire logic [cvcc_pkg::CH_FIELD_W-1:0]     in_ch,
   input  wire logic [cvcc_pkg::VAL_W-1:0]          in_level,
   input  wire logic [cvcc_pkg::MAPCC_W-1:0]        in_map_cc,
   input  wire cvcc_pkg::tick_type                  tick,
   output logic                                     in_ready,
   output logic                                     out_valid,
   input  wire logic                                out_ready,
   output logic      [cvcc_pkg::CC_W-1:0]           out_cc,
   output logic      [cvcc_pkg::VAL_W-1:0]          out_value,
   output logic      [cvcc_pkg::STAMP_W-1:0]        out_stamp,
   output logic                                     out_last
);

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CI_W = $clog2(NUM_CC);
   localparam logic [CH_W-1:0] CH_LAST   = CH_W'(NUM_CHANNELS - 1);
   localparam logic [CI_W-1:0] INIT_LAST = CI_W'(NUM_CC - 1);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_MAP_RD,
      ST_MAP_WR,
      ST_SCAN_RD,
      ST_SCAN_CC,
      ST_SCAN_CMP,
      ST_FLUSH
   } state_type;

   state_type state_ff;

   logic [cvcc_pkg::VAL_W-1:0]   level_mem_ff [NUM_CHANNELS];
   logic [cvcc_pkg::MAPCC_W-1:0] map_mem_ff   [NUM_CHANNELS];
   logic [cvcc_pkg::MAPCC_W-1:0] sent_mem_ff  [NUM_CC];

   logic [cvcc_pkg::VAL_W-1:0]   level_rd_ff;
   logic [cvcc_pkg::MAPCC_W-1:0] map_rd_ff;
   logic [cvcc_pkg::MAPCC_W-1:0] sent_rd_ff;

   logic [CI_W-1:0]              init_ff;
   logic [CH_W-1:0]              idx_ff;
   logic [CH_W-1:0]              map_ch_ff;
   logic [cvcc_pkg::CC_W-1:0]    map_cc_ff;
   logic [cvcc_pkg::STAMP_W-1:0] stamp_ff;
   logic                         pend_valid_ff;
   logic [cvcc_pkg::CC_W-1:0]    pend_cc_ff;
   logic [cvcc_pkg::VAL_W-1:0]   pend_val_ff;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic [cvcc_pkg::CC_W-1:0]    out_cc_ff;
   logic [cvcc_pkg::VAL_W-1:0]   out_value_ff;
   logic [cvcc_pkg::STAMP_W-1:0] out_stamp_ff;
   logic                         out_last_ff;

   logic                         accept;
   logic                         ch_ok;
   logic [CH_W-1:0]              ch_idx;
   logic                         init_ch;
   logic                         out_free;
   logic                         out_load;
   logic                         differ;
   logic [CI_W-1:0]              scan_cc;

   logic                         level_we;
   logic [CH_W-1:0]              level_wa;
   logic [cvcc_pkg::VAL_W-1:0]   level_wd;
   logic                         map_we;
   logic [CH_W-1:0]              map_wa;
   logic [cvcc_pkg::MAPCC_W-1:0] map_wd;
   logic                         map_re;
   logic                         level_re;
   logic                         sent_we;
   logic [CI_W-1:0]              sent_wa;
   logic [cvcc_pkg::MAPCC_W-1:0] sent_wd;
   logic                         sent_re;

   assign in_ready = (state_ff == ST_IDLE);
   assign accept   = in_valid && in_ready;
   assign ch_ok    = int'(in_ch) < NUM_CHANNELS;
   assign ch_idx   = CH_W'(in_ch);
   assign init_ch  = int'(init_ff) < NUM_CHANNELS;
   assign out_free = !out_valid_ff || out_ready;
   assign differ   = sent_rd_ff != {1'b0, level_rd_ff};
   assign scan_cc  = CI_W'(map_rd_ff[cvcc_pkg::CC_W-1:0]);

   assign out_load     = ((state_ff == ST_SCAN_CMP) && differ && pend_valid_ff && out_free)
                         || ((state_ff == ST_FLUSH) && pend_valid_ff && out_free);
   assign out_valid_in = out_load || (out_valid_ff && !out_ready);

   always_comb begin
      level_we = 1'b0;
      level_wa = ch_idx;
      level_wd = in_level;
      map_we   = 1'b0;
      map_wa   = ch_idx;
      map_wd   = cvcc_pkg::CC_NONE;
      sent_we  = 1'b0;
      sent_wa  = init_ff;
      sent_wd  = cvcc_pkg::SENT_NONE;
      case (state_ff)
         ST_INIT: begin
            level_we = init_ch;
            level_wa = CH_W'(init_ff);
            level_wd = '0;
            map_we   = init_ch;
            map_wa   = CH_W'(init_ff);
            map_wd   = cvcc_pkg::MAPCC_W'(init_ff);
            sent_we  = 1'b1;
         end
         ST_IDLE: begin
            level_we = accept && (in_op == cvcc_pkg::OP_SAMPLE) && ch_ok;
            map_we   = accept && (in_op == cvcc_pkg::OP_MAP) && ch_ok
                       && in_map_cc[cvcc_pkg::MAPCC_W-1];
         end
         ST_MAP_WR: begin
            map_wa = idx_ff;
            if (idx_ff == map_ch_ff) begin
               map_we = 1'b1;
               map_wd = {1'b0, map_cc_ff};
            end else begin
               map_we = map_rd_ff == {1'b0, map_cc_ff};
            end
         end
         ST_SCAN_CMP: begin
            sent_we = differ && (!pend_valid_ff || out_free);
            sent_wa = scan_cc;
            sent_wd = {1'b0, level_rd_ff};
         end
         default: ;
      endcase
   end

   assign map_re   = (state_ff == ST_MAP_RD) || (state_ff == ST_SCAN_RD);
   assign level_re = (state_ff == ST_SCAN_RD);
   assign sent_re  = (state_ff == ST_SCAN_CC) && !map_rd_ff[cvcc_pkg::MAPCC_W-1];

   always_ff @(posedge clock) begin
      if (level_we) level_mem_ff[level_wa] <= level_wd;
      if (level_re) level_rd_ff <= level_mem_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (map_we) map_mem_ff[map_wa] <= map_wd;
      if (map_re) map_rd_ff <= map_mem_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (sent_we) sent_mem_ff[sent_wa] <= sent_wd;
      if (sent_re) sent_rd_ff <= sent_mem_ff[scan_cc];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         init_ff       <= '0;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         case (state_ff)
            ST_INIT: begin
               init_ff <= init_ff + CI_W'(1);
               if (init_ff == INIT_LAST) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (in_valid) begin
                  idx_ff <= '0;
                  case (in_op)
                     cvcc_pkg::OP_MAP: begin
                        if (ch_ok && !in_map_cc[cvcc_pkg::MAPCC_W-1]) begin
                           map_ch_ff <= ch_idx;
                           map_cc_ff <= in_map_cc[cvcc_pkg::CC_W-1:0];
                           state_ff  <= ST_MAP_RD;
                        end
                     end
                     cvcc_pkg::OP_TICK: begin
                        if (tick.fire) begin
                           stamp_ff <= tick.stamp;
                           state_ff <= ST_SCAN_RD;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_MAP_RD: state_ff <= ST_MAP_WR;
            ST_MAP_WR: begin
               if (idx_ff == CH_LAST) begin
                  state_ff <= ST_IDLE;
               end else begin
                  idx_ff   <= idx_ff + CH_W'(1);
                  state_ff <= ST_MAP_RD;
               end
            end
            ST_SCAN_RD: state_ff <= ST_SCAN_CC;
            ST_SCAN_CC: begin
               if (!map_rd_ff[cvcc_pkg::MAPCC_W-1]) begin
                  state_ff <= ST_SCAN_CMP;
               end else if (idx_ff == CH_LAST) begin
                  state_ff <= ST_FLUSH;
               end else begin
                  idx_ff   <= idx_ff + CH_W'(1);
                  state_ff <= ST_SCAN_RD;
               end
            end
            ST_SCAN_CMP: begin
               if (!differ || !pend_valid_ff || out_free) begin
                  if (differ) begin
                     if (pend_valid_ff) begin
                        out_cc_ff    <= pend_cc_ff;
                        out_value_ff <= pend_val_ff;
                        out_stamp_ff <= stamp_ff;
                        out_last_ff  <= 1'b0;
                     end
                     pend_valid_ff <= 1'b1;
                     pend_cc_ff    <= map_rd_ff[cvcc_pkg::CC_W-1:0];
                     pend_val_ff   <= level_rd_ff;
                  end
                  if (idx_ff == CH_LAST) begin
                     state_ff <= ST_FLUSH;
                  end else begin
                     idx_ff   <= idx_ff + CH_W'(1);
                     state_ff <= ST_SCAN_RD;
                  end
               end
            end
            ST_FLUSH: begin
               if (!pend_valid_ff) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  out_cc_ff     <= pend_cc_ff;
                  out_value_ff  <= pend_val_ff;
                  out_stamp_ff  <= stamp_ff;
                  out_last_ff   <= 1'b1;
                  pend_valid_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign out_valid = out_valid_ff;
   assign out_cc    = out_cc_ff;
   assign out_value = out_value_ff;
   assign out_stamp = out_stamp_ff;
   assign out_last  = out_last_ff;

endmodule
`default_nettype wire

>>> src/cv_to_midi_cc_scanner_core.sv
// Top level of the CV to MIDI CC scanner.
//
//  Channel  Side  Beat contents
//  req      in    tuser: op; tdata: channel, sample_code, map_cc
//  rsp      out   tdata: cc_number, cc_value, frame_stamp; tlast: last_in_run
//  csr      APB   phase_step at 0x0, emit_period at 0x4
//
// Sample write, unassign, non-firing tick and unused op are handled in ST_IDLE, which stays ready.
// Bind to a controller: a read-modify-write sweep of the map memory (ST_MAP_RD, ST_MAP_WR per channel).
// Firing tick: a scan that reads the map and level of each channel (ST_SCAN_RD), then for a
// mapped channel reads the last-sent value (ST_SCAN_CC) and compares it (ST_SCAN_CMP), then
// ST_FLUSH; it waits while rsp stalls (one beat held, one pending).
// After reset a clearing pass over the NUM_CC entries fills the memories; req_tready stays low.
`timescale 1ns / 1ps
`default_nettype none
module cv_to_midi_cc_scanner_core #(
   parameter int NUM_CHANNELS = cvcc_pkg::NUM_CHANNELS_DEF,
   parameter int NUM_CC       = cvcc_pkg::NUM_CC_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [5:0] channel, [21:6] sample_code, [29:22] map_cc, [31:30] zero
   input  wire logic [cvcc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] op
   input  wire logic [1:0]                          req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [6:0] cc_number, [13:7] cc_value, [61:14] frame_stamp, [63:62] zero
   output logic      [cvcc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                     rsp_tlast,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [cvcc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [cvcc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [cvcc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready
);

   cvcc_pkg::cfg_type                cfg;
   cvcc_pkg::tick_type               tick;
   cvcc_pkg::op_type                 op;
   logic [cvcc_pkg::CH_FIELD_W-1:0]  channel;
   logic signed [cvcc_pkg::CODE_W-1:0] sample_code;
   logic [cvcc_pkg::MAPCC_W-1:0]     map_cc;
   logic [cvcc_pkg::VAL_W-1:0]       level;
   logic                             tick_accept;
   logic [cvcc_pkg::CC_W-1:0]        cc_number;
   logic [cvcc_pkg::VAL_W-1:0]       cc_value;
   logic [cvcc_pkg::STAMP_W-1:0]     frame_stamp;

   assign op          = cvcc_pkg::op_type'(req_tuser);
   assign channel     = req_tdata[5:0];
   assign sample_code = req_tdata[21:6];
   assign map_cc      = req_tdata[29:22];
   assign tick_accept = req_tvalid && req_tready && (op == cvcc_pkg::OP_TICK);

   cvcc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   cvcc_rate u_rate (
      .clock       (clock),
      .reset       (reset),
      .tick_accept (tick_accept),
      .cfg         (cfg),
      .tick        (tick)
   );

   cvcc_quant u_quant (
      .code  (sample_code),
      .level (level)
   );

   cvcc_engine #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .NUM_CC       (NUM_CC)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_op     (op),
      .in_ch     (channel),
      .in_level  (level),
      .in_map_cc (map_cc),
      .tick      (tick),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_cc    (cc_number),
      .out_value (cc_value),
      .out_stamp (frame_stamp),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, frame_stamp, cc_value, cc_number};

endmodule
`default_nettype wire

>>> src/cvcc_checker.sv
// Port-level checks of the CV to MIDI CC scanner, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cvcc_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic [cvcc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input wire logic [1:0]                          req_tuser,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [cvcc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input wire logic                                rsp_tlast,
   input wire logic                                csr_psel,
   input wire logic                                csr_penable,
   input wire logic                                csr_pwrite,
   input wire logic [cvcc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input wire logic [cvcc_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   input wire logic [cvcc_pkg::CSR_DATA_W-1:0]     csr_prdata,
   input wire logic                                csr_pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   a_init_busy: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req_tready high during clearing pass");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("rsp beat one cycle after request beat");

   a_run_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken before scan run ended");

endmodule

bind cv_to_midi_cc_scanner_core cvcc_checker u_cvcc_checker (.*);
`default_nettype wire

>>> dv/cv_to_midi_cc_scanner_core_tb.sv
// Self-checking testbench for the CV to MIDI CC scanner core.
`timescale 1ns / 1ps
module cv_to_midi_cc_scanner_core_tb;
   import cvcc_pkg::*;

   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 256;
   localparam int TAIL_CYCLES   = 256;
   localparam int PHASE_ITEMS   = 36;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int unsigned ACC_CEIL = (1 << ACC_W) - 1;
   localparam logic [CSR_ADDR_W-1:0] ADDR_PHASE_STEP  = {REG_PHASE_STEP, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_EMIT_PERIOD = {REG_EMIT_PERIOD, 2'b00};

   typedef enum int {
      RSP_ALWAYS,
      RSP_RANDOM,
      RSP_PATTERN
   } rsp_style_type;

   typedef struct {
      logic [CC_W-1:0]    cc;
      logic [VAL_W-1:0]   level;
      logic [STAMP_W-1:0] stamp;
      logic               last;
   } cc_msg_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // scanner state as the testbench tracks it
   logic [VAL_W-1:0]   level_mem [NUM_CHANNELS_DEF];
   logic [MAPCC_W-1:0] cc_map    [NUM_CHANNELS_DEF];
   logic [MAPCC_W-1:0] sent_val  [NUM_CC_DEF];
   int unsigned        rate_acc;
   logic [STAMP_W-1:0] tick_total;
   logic [CFG_W-1:0]   step_reg;
   logic [CFG_W-1:0]   period_reg;

   cc_msg_type    cc_msgs_due[$];
   int            error_count = 0;
   int            quiet_cycles = 0;
   int            burst_left = 0;
   int            gap_max = 0;
   rsp_style_type rsp_style = RSP_ALWAYS;
   logic [15:0]   rsp_pattern = 16'h1;

   cv_to_midi_cc_scanner_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch in %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic logic [VAL_W-1:0] cv_to_level(input logic [CODE_W-1:0] code);
      int unsigned q;
      if (code[CODE_W-1]) return '0;
      q = (QUANT_GAIN * code + QUANT_BIAS) / QUANT_DIV;
      return (q > 127) ? VAL_W'(127) : VAL_W'(q);
   endfunction

   task automatic reset_scanner_model();
      for (int i = 0; i < NUM_CHANNELS_DEF; i++) begin
         level_mem[i] = '0;
         cc_map[i]    = MAPCC_W'(i);
      end
      for (int i = 0; i < NUM_CC_DEF; i++) sent_val[i] = SENT_NONE;
      rate_acc   = 0;
      tick_total = '0;
      step_reg   = PHASE_STEP_RST;
      period_reg = EMIT_PERIOD_RST;
   endtask

   task automatic scan_for_changes(input logic [STAMP_W-1:0] stamp);
      int          sent;
      cc_msg_type  msg;
      logic [MAPCC_W-1:0] cc;
      sent = 0;
      for (int i = 0; i < NUM_CHANNELS_DEF; i++) begin
         cc = cc_map[i];
         if (cc[MAPCC_W-1]) continue;
         if (sent_val[cc[CC_W-1:0]] == {1'b0, level_mem[i]}) continue;
         sent_val[cc[CC_W-1:0]] = {1'b0, level_mem[i]};
         msg.cc    = cc[CC_W-1:0];
         msg.level = level_mem[i];
         msg.stamp = stamp;
         msg.last  = 1'b0;
         cc_msgs_due.push_back(msg);
         sent++;
      end
      if (sent > 0) cc_msgs_due[cc_msgs_due.size()-1].last = 1'b1;
   endtask

   task automatic predict_cc_messages(input logic [1:0] op, input logic [5:0] ch,
                                      input logic [CODE_W-1:0] code,
                                      input logic [MAPCC_W-1:0] cc);
      int unsigned        acc;
      logic [STAMP_W-1:0] stamp;
      case (op)
         OP_SAMPLE: begin
            level_mem[ch] = cv_to_level(code);
         end
         OP_MAP: begin
            if (!cc[MAPCC_W-1]) begin
               for (int i = 0; i < NUM_CHANNELS_DEF; i++)
                  if (cc_map[i] == cc) cc_map[i] = CC_NONE;
               cc_map[ch] = cc;
            end else begin
               cc_map[ch] = CC_NONE;
            end
         end
         OP_TICK: begin
            stamp      = tick_total;
            tick_total = tick_total + 1'b1;
            acc        = rate_acc + step_reg;
            if (acc >= period_reg) begin
               acc      = acc - period_reg;
               rate_acc = (acc > ACC_CEIL) ? ACC_CEIL : acc;
               scan_for_changes(stamp);
            end else begin
               rate_acc = (acc > ACC_CEIL) ? ACC_CEIL : acc;
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [1:0] op, input logic [5:0] ch,
                            input logic [CODE_W-1:0] code, input logic [MAPCC_W-1:0] cc);
      if (burst_left == 0) begin
         if (gap_max > 0) begin
            req_tvalid = 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tuser  = op;
      req_tdata  = {2'b00, cc, code, ch};
      req_tvalid = 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      predict_cc_messages(op, ch, code, cc);
      @(negedge clock);
   endtask

   task automatic send_random_item();
      logic [1:0]         op;
      logic [5:0]         ch;
      logic [CODE_W-1:0]  code;
      logic [MAPCC_W-1:0] cc;
      int                 pick;
      pick = $urandom_range(0, 99);
      ch   = 6'($urandom_range(0, NUM_CHANNELS_DEF - 1));
      code = CODE_W'($urandom);
      cc   = MAPCC_W'($urandom);
      if (pick < 45)      op = OP_SAMPLE;
      else if (pick < 85) op = OP_TICK;
      else if (pick < 96) op = OP_MAP;
      else                op = OP_UNUSED;
      case ($urandom_range(0, 4))
         1: code = 16'h7FFF;
         2: code = 16'h8000;
         3: code[CODE_W-1] = 1'b0;
         4: code = CODE_W'($urandom_range(0, 300));
         default: ;
      endcase
      case ($urandom_range(0, 3))
         0: cc = MAPCC_W'($urandom_range(0, 63));
         1: cc = MAPCC_W'($urandom_range(0, 127));
         2: cc = CC_NONE;
         default: ;
      endcase
      send_item(op, ch, code, cc);
   endtask

   // drop valid and wait out any scan or map sweep still running
   task automatic settle();
      req_tvalid = 1'b0;
      burst_left = 0;
      while (cc_msgs_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = write;
      csr_paddr   = addr;
      csr_pwdata  = wdata;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic csr_expect(input logic [CSR_ADDR_W-1:0] addr, input logic [CFG_W-1:0] want);
      logic [CSR_DATA_W-1:0] rdata;
      csr_access(1'b0, addr, '0, rdata);
      if (rdata !== CSR_DATA_W'(want)) report_mismatch("register readback", rdata, want);
   endtask

   task automatic set_rate(input logic [CFG_W-1:0] step, input logic [CFG_W-1:0] period);
      logic [CSR_DATA_W-1:0] unused;
      settle();
      csr_access(1'b1, ADDR_PHASE_STEP, CSR_DATA_W'(step), unused);
      step_reg = step;
      csr_access(1'b1, ADDR_EMIT_PERIOD, CSR_DATA_W'(period), unused);
      period_reg = period;
      csr_expect(ADDR_PHASE_STEP, step);
      csr_expect(ADDR_EMIT_PERIOD, period);
   endtask

   task automatic test_register_defaults();
      settle();
      csr_expect(ADDR_PHASE_STEP, PHASE_STEP_RST);
      csr_expect(ADDR_EMIT_PERIOD, EMIT_PERIOD_RST);
      send_item(OP_TICK, 6'd0, 16'h0000, 8'h00);
      send_item(OP_SAMPLE, 6'd1, 16'h7FFF, 8'h00);
      send_item(OP_TICK, 6'd0, 16'h0000, 8'h00);
   endtask

   task automatic test_scan_basics();
      set_rate(16'd1, 16'd1);
      gap_max   = 0;
      rsp_style = RSP_PATTERN;
      rsp_pattern = 16'b1011_0000_0111_0001;
      send_item(OP_TICK, 6'd0, 16'h0000, 8'h00);
      send_item(OP_TICK, 6'd0, 16'h0000, 8'h00);
      send_item(OP_SAMPLE, 6'd0, 16'h7FFF, 8'h00);
      send_item(OP_SAMPLE, 6'd63, 16'h8000, 8'h00);
      send_item(OP_SAMPLE, 6'd2, 16'd130, 8'h00);
      send_item(OP_SAMPLE, 6'd3, 16'd129, 8'h00);
      send_item(OP_SAMPLE, 6'd5, 16'hFFFF, 8'h00);
      send_item(OP_MAP, 6'd7, 16'h0000, 8'd0);
      send_item(OP_MAP, 6'd8, 16'h0000, CC_NONE);
      send_item(OP_MAP, 6'd9, 16'h0000, 8'h80);
      send_item(OP_MAP, 6'd10, 16'h0000, 8'd127);
      send_item(OP_UNUSED, 6'd1, 16'h7FFF, 8'd5);
      send_item(OP_TICK, 6'd0, 16'h0000, 8'h00);
      send_item(OP_SAMPLE, 6'd7, 16'h4000, 8'h00);
      send_item(OP_TICK, 6'd0, 16'h0000, 8'h00);
      send_item(OP_TICK, 6'd0, 16'h0000, 8'h00);
   endtask

   task automatic test_accumulator_extremes();
      set_rate(16'hFFFF, 16'd1);
      gap_max   = 4;
      rsp_style = RSP_RANDOM;
      for (int i = 0; i < 3; i++) begin
         send_item(OP_SAMPLE, 6'(i), 16'(i * 9000 + 500), 8'h00);
         send_item(OP_TICK, 6'd0, 16'h0000, 8'h00);
      end
      set_rate(16'd1, 16'hFFFF);
      repeat (3) send_item(OP_TICK, 6'd0, 16'h0000, 8'h00);
      set_rate(16'd0, 16'd0);
      send_item(OP_SAMPLE, 6'd4, 16'h2000, 8'h00);
      repeat (2) send_item(OP_TICK, 6'd0, 16'h0000, 8'h00);
      set_rate(16'hFFFF, 16'hFFFF);
      send_item(OP_SAMPLE, 6'd4, 16'h7000, 8'h00);
      send_item(OP_TICK, 6'd0, 16'h0000, 8'h00);
   endtask

   task automatic test_random_traffic();
      int step;
      int period;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin step = 1; period = 1; end
            1: begin step = 3; period = 7; end
            2: begin step = 65535; period = 65535; end
            3: begin
               step   = $urandom_range(256, 65535);
               period = $urandom_range(step / 4 + 1, (step * 2 > 65535) ? 65535 : step * 2);
            end
            default: begin step = 0; period = 0; end
         endcase
         set_rate(CFG_W'(step), CFG_W'(period));
         gap_max     = (phase == 0) ? 0 : $urandom_range(1, 8);
         rsp_style   = rsp_style_type'(phase % 3);
         rsp_pattern = 16'($urandom) | 16'h1;
         repeat (PHASE_ITEMS) send_random_item();
      end
   endtask

   always @(negedge clock) begin
      case (rsp_style)
         RSP_ALWAYS: rsp_tready = 1'b1;
         RSP_RANDOM: rsp_tready = ($urandom_range(0, 2) != 0);
         default: begin
            rsp_tready  = rsp_pattern[0];
            rsp_pattern = {rsp_pattern[0], rsp_pattern[15:1]};
         end
      endcase
   end

   always @(posedge clock) begin
      cc_msg_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (cc_msgs_due.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata, '0);
         end else begin
            want = cc_msgs_due.pop_front();
            if (rsp_tdata[6:0] !== want.cc)
               report_mismatch("cc_number", rsp_tdata[6:0], want.cc);
            if (rsp_tdata[13:7] !== want.level)
               report_mismatch("cc_value", rsp_tdata[13:7], want.level);
            if (rsp_tdata[61:14] !== want.stamp)
               report_mismatch("frame_stamp", rsp_tdata[61:14], want.stamp);
            if (rsp_tlast !== want.last)
               report_mismatch("last_in_run", rsp_tlast, want.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset_scanner_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_register_defaults();
      test_scan_basics();
      test_accumulator_extremes();
      test_random_traffic();
      req_tvalid = 1'b0;
      while (cc_msgs_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
